// ===== hdl/fmr_pkg.sv =====
package fmr_pkg;

    // Default and limits of the pattern window.
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPL_MAX        = 8;

    // Fixed field widths: lengths reach 8, positions reach 7.
    localparam int LEN_W  = 4;
    localparam int POS_W  = 3;
    localparam int WORD_W = 64;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;

    // Entries in the burst queue between front and back (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    // Effective settings as seen by the search logic.
    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic [WORD_W-1:0] replacement;
        logic [LEN_W-1:0]  plen;
        logic [LEN_W-1:0]  rlen;
    } cfg_t;

    // Control part of one burst: the bytes at positions start down to
    // start - count + 1 leave, oldest first.
    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] count;
        logic             last;
    } burst_ctl_t;

endpackage

// ===== hdl/first_match_replace_stream.sv =====
// Channel  | Signals                                   | Direction | Handshake
// ---------+-------------------------------------------+-----------+-------------------------
// input    | data_byte, chunk_end                      | in        | in_valid / in_stall
// output   | out_byte, out_last, was_replaced          | out       | out_valid / out_stall
// config   | cfg_index, cfg_data                       | in        | cfg_valid / cfg_ready
//
// One byte is taken per cycle while the queue is not full; the front compares the new byte
// and the window against the pattern combinationally and hands a burst of 1 to PATTERN_MAX
// bytes to a four-entry queue. The back sends one byte per cycle while out_stall is low, so a
// match or a chunk end with pending bytes stalls the input once the queue fills.
// Once its burst is formed, a byte is written to the queue and then loaded into the output register.
// Reset clears the search state, the queue pointers, the output valid flag and all settings.
// in_stall is high exactly while the queue is full; out_stall holds the output register.
module first_match_replace_stream
    import fmr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   chunk_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output logic                   was_replaced,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    localparam int ENTRY_W = $bits(burst_ctl_t) + PATTERN_MAX * 9;

    cfg_t                     cfg;
    logic                     accept;
    logic                     q_push;
    logic                     q_pop;
    logic                     q_valid;
    logic                     q_full;
    logic [PATTERN_MAX*8-1:0] entry_bytes;
    logic [PATTERN_MAX-1:0]   entry_repl;
    burst_ctl_t               entry_ctl;
    logic [ENTRY_W-1:0]       q_wdata;
    logic [ENTRY_W-1:0]       q_rdata;
    logic [PATTERN_MAX*8-1:0] head_bytes;
    logic [PATTERN_MAX-1:0]   head_repl;
    burst_ctl_t               head_ctl;

    // Input is held off only by a full queue.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Settings.
    fmr_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Search and classification.
    fmr_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .chunk_end   (chunk_end),
        .cfg         (cfg),
        .push        (q_push),
        .entry_bytes (entry_bytes),
        .entry_repl  (entry_repl),
        .entry_ctl   (entry_ctl)
    );

    // Burst queue.
    assign q_wdata = {entry_ctl, entry_repl, entry_bytes};

    fmr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid),
        .full  (q_full)
    );

    assign {head_ctl, head_repl, head_bytes} = q_rdata;

    // Byte output.
    fmr_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_bytes   (head_bytes),
        .head_repl    (head_repl),
        .head_ctl     (head_ctl),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .was_replaced (was_replaced)
    );

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("burst pushed into a full queue");

    // The back only retires a burst that is present.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("burst popped from an empty queue");

    // Every queued burst is non-empty and fits the window below its start.
    a_head_sane: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (head_ctl.count != '0) &&
                    (head_ctl.count <= LEN_W'(PATTERN_MAX)) &&
                    (({1'b0, head_ctl.start} + 1'b1) >= head_ctl.count))
        else $error("queued burst has a bad start or count");

endmodule

// ===== hdl/fmr_cfg.sv =====
module fmr_cfg
    import fmr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    logic [WORD_W-1:0] pattern_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [WORD_W-1:0] replacement_reg;
    logic [LEN_W-1:0]  rlen_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            plen_reg        <= '0;
            replacement_reg <= '0;
            rlen_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:      pattern_reg     <= cfg_data;
                REG_PATTERN_LENGTH:     plen_reg        <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_reg <= cfg_data;
                REG_REPLACEMENT_LENGTH: rlen_reg        <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // Lengths beyond the window or the replacement act as the maximum.
    always_comb
    begin
        cfg.pattern     = pattern_reg;
        cfg.replacement = replacement_reg;
        cfg.plen        = (plen_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_reg;
        cfg.rlen        = (rlen_reg > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : rlen_reg;
    end

endmodule

// ===== hdl/fmr_front.sv =====
module fmr_front
    import fmr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     chunk_end,
    input  cfg_t                     cfg,
    output logic                     push,
    output logic [PATTERN_MAX*8-1:0] entry_bytes,
    output logic [PATTERN_MAX-1:0]   entry_repl,
    output burst_ctl_t               entry_ctl
);

    localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    // Pending bytes, newest at entry 0.
    logic [7:0]       win_reg [WIN_DEPTH];
    logic [LEN_W-1:0] fill_reg;
    logic             match_done_reg;
    logic [LEN_W-1:0] replace_index_reg;

    logic [LEN_W-1:0] fill_next;
    logic             match_done_next;
    logic [LEN_W-1:0] replace_index_next;

    // Candidate bytes: the new byte at 0, then the pending ones, older upward.
    logic [7:0]             cand   [PATTERN_MAX];
    logic [7:0]             pat_al [PATTERN_MAX];
    logic [7:0]             rep_al [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] in_pat;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] rmask;
    logic [LEN_W-1:0]       fill_len;
    logic                   hit;
    logic                   use_rep;
    logic [7:0]             rep_at_index;

    assign fill_len = fill_reg + 1'b1;

    // Candidates and the pattern aligned to them from the newest byte back.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        for (int d = 0; d < PATTERN_MAX; d++)
        begin
            if (d == 0)
            begin
                cand[d] = data_byte;
            end
            else
            begin
                cand[d] = win_reg[d-1];
            end
            idx       = LEN_W'(cfg.plen - LEN_W'(d + 1));
            pat_al[d] = cfg.pattern[{idx[POS_W-1:0], 3'b000} +: 8];
            rep_al[d] = cfg.replacement[{idx[POS_W-1:0], 3'b000} +: 8];
            in_pat[d] = LEN_W'(d) < cfg.plen;
            eq[d]     = !in_pat[d] || (cand[d] == pat_al[d]);
            rmask[d]  = in_pat[d] &&
                        (({1'b0, LEN_W'(d)} + {1'b0, cfg.rlen}) >= {1'b0, cfg.plen});
        end
    end

    assign hit = !match_done_reg && (cfg.plen != '0) && (fill_len >= cfg.plen) && (&eq);

    // Replacement byte that follows a match.
    assign use_rep      = replace_index_reg < cfg.rlen;
    assign rep_at_index = cfg.replacement[{replace_index_reg[POS_W-1:0], 3'b000} +: 8];

    // Classify the item and build its burst.
    always_comb
    begin
        for (int d = 0; d < PATTERN_MAX; d++)
        begin
            entry_bytes[d*8 +: 8] = cand[d];
        end
        entry_repl         = '0;
        entry_ctl.start    = '0;
        entry_ctl.count    = '0;
        entry_ctl.last     = chunk_end;
        fill_next          = fill_reg;
        match_done_next    = match_done_reg;
        replace_index_next = replace_index_reg;

        if (match_done_reg)
        begin
            // After the match: replacement tail or the byte itself.
            entry_bytes[7:0]   = use_rep ? rep_at_index : data_byte;
            entry_repl[0]      = use_rep;
            entry_ctl.count    = LEN_W'(1);
            replace_index_next = replace_index_reg + LEN_W'(use_rep);
        end
        else if (cfg.plen == '0)
        begin
            // Empty pattern: pending bytes leave as they are, this byte starts the match.
            entry_bytes[7:0]   = (cfg.rlen != '0) ? cfg.replacement[7:0] : data_byte;
            entry_repl[0]      = cfg.rlen != '0;
            entry_ctl.start    = fill_reg[POS_W-1:0];
            entry_ctl.count    = fill_len;
            fill_next          = '0;
            match_done_next    = 1'b1;
            replace_index_next = LEN_W'(cfg.rlen != '0);
        end
        else if (hit)
        begin
            // Match at the tail: everything leaves, with up to rlen of the oldest match bytes overwritten.
            for (int d = 0; d < PATTERN_MAX; d++)
            begin
                if (rmask[d])
                begin
                    entry_bytes[d*8 +: 8] = rep_al[d];
                end
            end
            entry_repl         = rmask;
            entry_ctl.start    = fill_reg[POS_W-1:0];
            entry_ctl.count    = fill_len;
            fill_next          = '0;
            match_done_next    = 1'b1;
            replace_index_next = (cfg.plen < cfg.rlen) ? cfg.plen : cfg.rlen;
        end
        else if (chunk_end)
        begin
            // Chunk end without a match: flush the whole window.
            entry_ctl.start = fill_reg[POS_W-1:0];
            entry_ctl.count = fill_len;
            fill_next       = '0;
        end
        else if (fill_len >= cfg.plen)
        begin
            // Keep only the bytes that may still start a match.
            entry_ctl.start = fill_reg[POS_W-1:0];
            entry_ctl.count = fill_len - cfg.plen + 1'b1;
            fill_next       = cfg.plen - 1'b1;
        end
        else
        begin
            fill_next = fill_len;
        end

        if (chunk_end)
        begin
            fill_next          = '0;
            match_done_next    = 1'b0;
            replace_index_next = '0;
        end
    end

    assign push = accept && (entry_ctl.count != '0);

    // Search state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg          <= '0;
            match_done_reg    <= 1'b0;
            replace_index_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg          <= fill_next;
            match_done_reg    <= match_done_next;
            replace_index_reg <= replace_index_next;
        end
    end

    // Window shift line; the new byte always enters at the front.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= data_byte;
            for (int d = 1; d < WIN_DEPTH; d++)
            begin
                win_reg[d] <= win_reg[d-1];
            end
        end
    end

endmodule

// ===== hdl/fmr_queue.sv =====
module fmr_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   rd_ptr_reg;

    // Status from the wrap bit and the index bits.
    assign valid = wr_ptr_reg != rd_ptr_reg;
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign rdata = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= wdata;
        end
    end

endmodule

// ===== hdl/fmr_back.sv =====
module fmr_back
    import fmr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  logic [PATTERN_MAX*8-1:0] head_bytes,
    input  logic [PATTERN_MAX-1:0]   head_repl,
    input  burst_ctl_t               head_ctl,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               out_byte,
    output logic                     out_last,
    output logic                     was_replaced
);

    logic [POS_W-1:0] sent_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             was_replaced_reg;

    logic             load;
    logic             final_byte;
    logic [POS_W-1:0] idx;

    // One byte of the head burst moves to the output register per cycle while the output is not stalled.
    assign load       = head_valid && (!out_valid_reg || !out_stall);
    assign idx        = head_ctl.start - sent_reg;
    assign final_byte = (LEN_W'(sent_reg) + 1'b1) == head_ctl.count;
    assign pop        = load && final_byte;

    // Position within the head burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sent_reg <= final_byte ? '0 : sent_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg     <= head_bytes[{idx, 3'b000} +: 8];
            was_replaced_reg <= head_repl[idx];
            out_last_reg     <= head_ctl.last && final_byte;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign was_replaced = was_replaced_reg;

endmodule
